/* rtl/rc4_stream_cipher_defines.svh */
// assertion macros for the rc4 stream cipher
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define RC4_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4 check failed");

// next-cycle implication, checked on clk outside reset
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 check failed");

`endif

/* rtl/rc4_pkg.sv */
// types and constants shared by the rc4 controller and datapath
package rc4_pkg;

	localparam int PERM_DEPTH = 256;
	localparam logic [8:0] KEY_LEN_RST = 9'd5;

	// request operation codes
	localparam logic [1:0] OP_RESET = 2'd0;
	localparam logic [1:0] OP_KEY   = 2'd1;
	localparam logic [1:0] OP_SCHED = 2'd2;
	localparam logic [1:0] OP_CRYPT = 2'd3;

	// permutation read address select
	localparam logic [2:0] RD_INEXT = 3'd0;
	localparam logic [2:0] RD_CJ    = 3'd1;
	localparam logic [2:0] RD_T     = 3'd2;
	localparam logic [2:0] RD_N     = 3'd3;
	localparam logic [2:0] RD_KJ    = 3'd4;

	// permutation write address/data select
	localparam logic [1:0] WR_I_RD  = 2'd0;
	localparam logic [1:0] WR_J_A   = 2'd1;
	localparam logic [1:0] WR_N_RD  = 2'd2;
	localparam logic [1:0] WR_KJ_A  = 2'd3;

	typedef struct packed {
		logic       latch;
		logic       perm_clear;
		logic       key_wr;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       cap_a;
		logic       j_upd;
		logic       cap_bt;
		logic       kj_upd;
		logic       ks_adv;
		logic       i_inc;
		logic       res_upd;
		logic       out_load;
	} rc4_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       ks_last;
	} rc4_sts_t;

endpackage

/* rtl/rc4_dp.sv */
// rc4 datapath: permutation memory, key store, indices and result registers
module rc4_dp
	import rc4_pkg::*;
#(
	parameter int KEY_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic [1:0] operation,
	input  logic [7:0] key_index,
	input  logic [7:0] key_byte,
	input  logic [7:0] data_byte,
	input  rc4_cmd_t   cmd,
	output rc4_sts_t   sts,
	output logic [7:0] out_byte
);

	localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [8:0] KEY_DEPTH_W = 9'(KEY_DEPTH);

	logic [8:0]  key_length_q;
	logic [1:0]  op_q;
	logic [7:0]  kidx_q;
	logic [7:0]  kbyte_q;
	logic [7:0]  data_q;
	logic [7:0]  i_q;
	logic [7:0]  j_q;
	logic [7:0]  kj_q;
	logic [7:0]  n_q;
	logic [KW-1:0] kpos_q;
	logic [7:0]  a_q;
	logic [7:0]  b_q;
	logic [7:0]  t_q;
	logic [7:0]  res_q;
	logic [7:0]  out_q;

	logic [7:0]  perm_mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] perm_vld_q;
	logic [7:0]  prd_q;
	logic [7:0]  pra_q;
	logic        prv_q;
	logic [7:0]  rd_data;
	logic [7:0]  rd_addr;
	logic [7:0]  wr_addr;
	logic [7:0]  wr_data;

	logic [7:0]  key_mem [KEY_DEPTH];
	logic [7:0]  kd_q;
	logic        key_ok;
	logic [8:0]  len_eff;
	logic [8:0]  kpos_inc;
	logic [KW-1:0] kpos_nxt;
	logic [7:0]  fwd;

	// entries not written since the last clear read as their own index
	assign rd_data = prv_q ? prd_q : pra_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_INEXT: rd_addr = i_q + 8'd1;
			RD_CJ:    rd_addr = j_q + rd_data;
			RD_T:     rd_addr = a_q + rd_data;
			RD_N:     rd_addr = n_q;
			RD_KJ:    rd_addr = kj_q + kd_q + rd_data;
			default:  rd_addr = n_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_I_RD: begin
				wr_addr = i_q;
				wr_data = rd_data;
			end
			WR_J_A: begin
				wr_addr = j_q;
				wr_data = a_q;
			end
			WR_N_RD: begin
				wr_addr = n_q;
				wr_data = rd_data;
			end
			default: begin
				wr_addr = kj_q;
				wr_data = a_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prd_q <= perm_mem[rd_addr];
		pra_q <= rd_addr;
		if (cmd.wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
			prv_q      <= 1'b0;
		end else begin
			prv_q <= perm_vld_q[rd_addr];
			if (cmd.perm_clear) begin
				perm_vld_q <= '0;
			end else if (cmd.wr_en) begin
				perm_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// key store
	assign key_ok = {1'b0, kidx_q} < KEY_DEPTH_W;

	always_ff @(posedge clk) begin
		if (cmd.key_wr && key_ok) begin
			key_mem[kidx_q[KW-1:0]] <= kbyte_q;
		end
		kd_q <= key_mem[kpos_q];
	end

	// zero or oversized length falls back to the full store
	assign len_eff  = (key_length_q == 9'd0 || key_length_q > KEY_DEPTH_W) ?
		KEY_DEPTH_W : key_length_q;
	assign kpos_inc = 9'(kpos_q) + 9'd1;
	assign kpos_nxt = (kpos_inc >= len_eff) ? '0 : kpos_inc[KW-1:0];

	// the keystream read was issued before the swap finished
	always_comb begin
		priority if (t_q == j_q) begin
			fwd = a_q;
		end else if (t_q == i_q) begin
			fwd = b_q;
		end else begin
			fwd = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LEN_RST;
			i_q          <= '0;
			j_q          <= '0;
		end else begin
			if (cfg_we) begin
				key_length_q <= cfg_wdata;
			end
			if (cmd.perm_clear) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (cmd.i_inc) begin
					i_q <= i_q + 8'd1;
				end
				if (cmd.j_upd) begin
					j_q <= j_q + rd_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= operation;
			kidx_q  <= key_index;
			kbyte_q <= key_byte;
			data_q  <= data_byte;
			n_q     <= '0;
			kpos_q  <= '0;
			kj_q    <= '0;
			res_q   <= '0;
		end else begin
			if (cmd.kj_upd) begin
				kj_q <= kj_q + kd_q + rd_data;
			end
			if (cmd.ks_adv) begin
				n_q    <= n_q + 8'd1;
				kpos_q <= kpos_nxt;
			end
			if (cmd.res_upd) begin
				res_q <= data_q ^ fwd;
			end
		end
		if (cmd.cap_a) begin
			a_q <= rd_data;
		end
		if (cmd.cap_bt) begin
			b_q <= rd_data;
			t_q <= a_q + rd_data;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign sts.op      = op_q;
	assign sts.ks_last = (n_q == 8'hFF);
	assign out_byte    = out_q;

endmodule

/* rtl/rc4_ctrl.sv */
// rc4 controller: sequences each request and owns the handshakes
module rc4_ctrl
	import rc4_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rc4_sts_t sts,
	output rc4_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_KS_RD = 4'd2;
	localparam logic [3:0] S_KS_J  = 4'd3;
	localparam logic [3:0] S_KS_W1 = 4'd4;
	localparam logic [3:0] S_KS_W2 = 4'd5;
	localparam logic [3:0] S_CR_J  = 4'd6;
	localparam logic [3:0] S_CR_W1 = 4'd7;
	localparam logic [3:0] S_CR_W2 = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_RESET: begin
						cmd.perm_clear = 1'b1;
						state_nxt      = S_FIN;
					end
					OP_KEY: begin
						cmd.key_wr = 1'b1;
						state_nxt  = S_FIN;
					end
					OP_SCHED: begin
						cmd.rd_sel = RD_N;
						state_nxt  = S_KS_J;
					end
					default: begin
						cmd.rd_sel = RD_INEXT;
						cmd.i_inc  = 1'b1;
						state_nxt  = S_CR_J;
					end
				endcase
			end
			S_KS_RD: begin
				cmd.rd_sel = RD_N;
				state_nxt  = S_KS_J;
			end
			S_KS_J: begin
				cmd.cap_a  = 1'b1;
				cmd.kj_upd = 1'b1;
				cmd.rd_sel = RD_KJ;
				state_nxt  = S_KS_W1;
			end
			S_KS_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_N_RD;
				state_nxt  = S_KS_W2;
			end
			S_KS_W2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_KJ_A;
				cmd.ks_adv = 1'b1;
				state_nxt  = sts.ks_last ? S_FIN : S_KS_RD;
			end
			S_CR_J: begin
				cmd.cap_a  = 1'b1;
				cmd.j_upd  = 1'b1;
				cmd.rd_sel = RD_CJ;
				state_nxt  = S_CR_W1;
			end
			S_CR_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_I_RD;
				cmd.cap_bt = 1'b1;
				cmd.rd_sel = RD_T;
				state_nxt  = S_CR_W2;
			end
			S_CR_W2: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_J_A;
				cmd.res_upd = 1'b1;
				state_nxt   = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/rc4_stream_cipher.sv */
// rc4 stream cipher engine top level
// Requests enter on in_valid/in_ready with operation, key_index, key_byte and
// data_byte; each request returns one out_byte on out_valid/out_ready.
// Operations: reset permutation, write key byte, run key schedule, crypt byte.
// out_byte carries data_byte xor keystream for crypt and zero otherwise.
// key_length is written through cfg_we/cfg_wdata; the user must write it only
// while the engine is idle, as the block itself does not enforce this.
// Reset and key write pass S_DISP and S_FIN; crypt passes S_DISP, S_CR_J,
// S_CR_W1, S_CR_W2 and S_FIN; the key schedule repeats S_KS_RD, S_KS_J, S_KS_W1
// and S_KS_W2 per permutation entry (the first step skips S_KS_RD), then S_FIN.
// One request is in flight at a time; in_ready is high only when idle.
// All permutation traffic goes through one 256x8 memory with one read and one
// write per cycle.
// A finished result sits in the output register while the next request is
// taken; if the receiver stalls, a second result waits inside until it drains.
// Reset (arst_n) sets the permutation to identity, clears both indices and
// sets key_length to 5; the key store holds no defined value until written.
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int KEY_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] key_index,
	input  logic [7:0] key_byte,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte
);

	rc4_cmd_t cmd;
	rc4_sts_t sts;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rc4_dp #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operation (operation),
		.key_index (key_index),
		.key_byte  (key_byte),
		.data_byte (data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_byte  (out_byte)
	);

	`RC4_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`RC4_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !out_valid || out_ready)
	`RC4_ASSERT_NOW(a_key_write_only_for_key_op, cmd.key_wr, sts.op == OP_KEY)
	`RC4_ASSERT_NOW(a_single_perm_action, cmd.perm_clear, !cmd.wr_en && !cmd.i_inc)

endmodule
